// ===== hdl/ipaf_pkg.sv =====
package ipaf_pkg;

   localparam logic [1:0] ACTION_ADD   = 2'd0;
   localparam logic [1:0] ACTION_CHECK = 2'd1;
   localparam logic [1:0] ACTION_CLEAR = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_BAD_LEN = 2'd2;

   localparam logic [5:0] PREFIX_MAX = 6'd32;
   localparam logic [31:0] ALL_ONES  = 32'hffff_ffff;

   // One query word as it travels down the row of rule cells.
   typedef struct packed {
      logic        active;
      logic [31:0] query;
      logic        hit;
      logic [3:0]  slot;
      logic        deny;
   } chain_type;

   // A prefix length of zero gives an empty mask, 32 gives all ones.
   function automatic logic [31:0] prefix_to_mask(input logic [5:0] plen);
      prefix_to_mask = ~(ALL_ONES >> plen);
   endfunction

endpackage

// ===== hdl/ipaf_cell.sv =====
module ipaf_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [31:0]          wr_network,
   input  logic [31:0]          wr_mask,
   input  logic                 wr_deny,
   input  logic                 in_use,
   input  logic [3:0]           cell_slot,
   input  ipaf_pkg::chain_type  up_chain,
   output ipaf_pkg::chain_type  down_chain
);

   logic [31:0]         network_ff;
   logic [31:0]         mask_ff;
   logic                deny_ff;
   logic                active_ff;
   ipaf_pkg::chain_type out_ff;
   ipaf_pkg::chain_type out_in;
   logic                match;

   assign match = up_chain.active && in_use && ((up_chain.query & mask_ff) == network_ff);

   // Cells further down hold newer rules, so a later hit replaces an earlier one.
   always_comb begin
      out_in = up_chain;
      if (match) begin
         out_in.hit  = 1'b1;
         out_in.slot = cell_slot;
         out_in.deny = deny_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= out_in.active;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (wr_en) begin
         network_ff <= wr_network;
         mask_ff    <= wr_mask;
         deny_ff    <= wr_deny;
      end
   end

   always_comb begin
      down_chain        = out_ff;
      down_chain.active = active_ff;
   end

endmodule

// ===== hdl/ipv4_prefix_access_filter_unit.sv =====
// Add, clear and undefined words: result registered in the cycle after acceptance.
// Check words: the query steps through the rule cells, one rule cell per cycle,
// and the result is registered after the last cell; one word is in the block at a time.
// A new word is taken only while no check is searching and the result side does not stall.
// Synchronous active-high reset empties the rule table and the result register.
module ipv4_prefix_access_filter_unit #(
   parameter int MAX_RULES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_rule_address,
   input  logic [5:0]  req_prefix_length,
   input  logic        req_deny_flag,
   input  logic [31:0] req_query_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_verdict,
   output logic        rsp_matched,
   output logic [3:0]  rsp_match_slot,
   output logic [1:0]  rsp_status
);

   localparam int CNT_W = $clog2(MAX_RULES + 1);

   logic [CNT_W-1:0]    count_ff, count_in;
   logic                busy_ff, busy_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                verdict_ff, verdict_in;
   logic                matched_ff, matched_in;
   logic [3:0]          slot_ff, slot_in;
   logic [1:0]          status_ff, status_in;
   logic                rsp_load;

   logic                req_accept;
   logic                is_add, is_check, is_clear;
   logic                bad_prefix, table_full, add_ok;
   logic [31:0]         new_mask;
   ipaf_pkg::chain_type link [MAX_RULES+1];
   ipaf_pkg::chain_type last;

   assign req_stall  = busy_ff || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;

   assign is_add     = (req_action == ipaf_pkg::ACTION_ADD);
   assign is_check   = (req_action == ipaf_pkg::ACTION_CHECK);
   assign is_clear   = (req_action == ipaf_pkg::ACTION_CLEAR);
   assign bad_prefix = (req_prefix_length > ipaf_pkg::PREFIX_MAX);
   assign table_full = (count_ff == CNT_W'(MAX_RULES));
   assign add_ok     = req_accept && is_add && !bad_prefix && !table_full;
   assign new_mask   = ipaf_pkg::prefix_to_mask(req_prefix_length);

   always_comb begin
      link[0]        = '0;
      link[0].active = req_accept && is_check;
      link[0].query  = req_query_address;
   end

   for (genvar i = 0; i < MAX_RULES; i++) begin : g_cell
      ipaf_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .wr_en      (add_ok && (count_ff == CNT_W'(i))),
         .wr_network (req_rule_address & new_mask),
         .wr_mask    (new_mask),
         .wr_deny    (req_deny_flag),
         .in_use     (count_ff > CNT_W'(i)),
         .cell_slot  (4'(i)),
         .up_chain   (link[i]),
         .down_chain (link[i+1])
      );
   end

   assign last = link[MAX_RULES];

   always_comb begin
      count_in = count_ff;
      if (add_ok) begin
         count_in = count_ff + 1'b1;
      end else if (req_accept && is_clear) begin
         count_in = '0;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (req_accept && is_check) begin
         busy_in = 1'b1;
      end else if (last.active) begin
         busy_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_load     = 1'b0;
      verdict_in   = 1'b0;
      matched_in   = 1'b0;
      slot_in      = '0;
      status_in    = ipaf_pkg::STATUS_OK;
      if (req_accept && !is_check) begin
         rsp_valid_in = 1'b1;
         rsp_load     = 1'b1;
         if (is_add && bad_prefix) begin
            status_in = ipaf_pkg::STATUS_BAD_LEN;
         end else if (is_add && table_full) begin
            status_in = ipaf_pkg::STATUS_FULL;
         end
      end else if (last.active) begin
         rsp_valid_in = 1'b1;
         rsp_load     = 1'b1;
         matched_in   = last.hit;
         slot_in      = last.hit ? last.slot : 4'd0;
         // An empty table allows; otherwise no hit forbids.
         if (count_ff != '0) begin
            verdict_in = last.hit ? last.deny : 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         verdict_ff <= verdict_in;
         matched_ff <= matched_in;
         slot_ff    <= slot_in;
         status_ff  <= status_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_verdict    = verdict_ff;
   assign rsp_matched    = matched_ff;
   assign rsp_match_slot = slot_ff;
   assign rsp_status     = status_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_RULES))
      else $error("rule count above table size");

   a_chain_busy : assert property (@(posedge clock) disable iff (reset)
      last.active |-> busy_ff)
      else $error("query left the cell row with no search in progress");

   a_result_free : assert property (@(posedge clock) disable iff (reset)
      last.active |-> !rsp_valid_ff)
      else $error("search finished while the result register was occupied");

   a_done_idle : assert property (@(posedge clock) disable iff (reset)
      last.active |=> !busy_ff && rsp_valid_ff)
      else $error("search end did not release the block and post a word");

endmodule
